>>> design/skf_pkg.sv
// Shared widths and register codes for the scalar Kalman filter.
package skf_pkg;

	localparam int DATA_W    = 32;           // Q.FRAC fields and registers
	localparam int ACC_W     = DATA_W + 1;   // prior + R, measurement - estimate
	localparam int CFG_IDX_W = 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PROCESS_NOISE     = 1'b0,
		REG_MEASUREMENT_NOISE = 1'b1
	} cfg_reg_t;

endpackage

>>> design/skf_div.sv
// Restoring divider, one quotient bit per cycle, for the Kalman gain.
module skf_div #(
	parameter int QW = 17
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [skf_pkg::DATA_W-1:0]    num,
	input  logic [skf_pkg::ACC_W-1:0]     den,
	output logic [QW-1:0]                 quo,
	output logic                          done
);

	localparam int CW = $clog2(QW);
	localparam int RW = skf_pkg::ACC_W + 1;

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [RW-1:0] rem_q;
	logic [QW-1:0] quo_q;

	logic          ge;
	logic [RW-1:0] rem_sub;

	// num <= den here, so the remainder stays below den and fits ACC_W bits
	assign ge      = rem_q >= {1'b0, den};
	assign rem_sub = ge ? (rem_q - {1'b0, den}) : rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(QW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {2'b00, num};
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= {rem_sub[RW-2:0], 1'b0};
			quo_q <= {quo_q[QW-2:0], ge};
		end
	end

	assign quo  = quo_q;
	assign done = done_q;

endmodule

>>> design/skf_mul.sv
// Bit-serial shift-add multiplier: signed A times unsigned B, LSB of B first,
// result rounded half up and scaled down by 2^(BW-1).
module skf_mul #(
	parameter int AW = 33,
	parameter int BW = 17
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [AW-1:0] a,
	input  logic [BW-1:0]        b,
	output logic signed [AW:0]   prod,
	output logic                 done
);

	localparam int CW = $clog2(BW);

	logic                 busy_q;
	logic                 done_q;
	logic [CW-1:0]        cnt_q;
	logic signed [AW-1:0] a_q;
	logic [BW-1:0]        bsh_q;
	logic signed [AW-1:0] hi_q;
	logic [1:0]           l_q;     // last two product bits shifted out

	logic signed [AW:0]   sum;

	assign sum = {hi_q[AW-1], hi_q} + (bsh_q[0] ? {a_q[AW-1], a_q} : {(AW+1){1'b0}});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(BW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			bsh_q <= b;
			hi_q  <= '0;
			l_q   <= '0;
		end else if (busy_q) begin
			hi_q  <= sum[AW:1];
			l_q   <= {sum[0], l_q[1]};
			bsh_q <= bsh_q >> 1;
		end
	end

	// floor((p + 2^(BW-2)) / 2^(BW-1)) = (p >>> (BW-1)) + p[BW-2]
	assign prod = $signed({hi_q, l_q[1]}) + $signed({{AW{1'b0}}, l_q[0]});
	assign done = done_q;

endmodule

>>> design/scalar_kalman_filter.sv
// One-dimensional Kalman filter (A = H = 1) in fixed point. Each non-restart
// word passes through adds for the prior and the denominator (ST_PRIOR,
// ST_DEN), GAIN_BITS+1 steps of a one-bit-per-cycle divider for the gain,
// then GAIN_BITS+1 steps of two bit-serial multipliers running side by side for
// the estimate correction and the posterior variance. A restart word goes
// straight from idle to the update state. One word is in flight at a time; a
// new word is accepted while the previous result still waits in the output
// register. Registers 0 (process noise) and 1 (measurement noise) are unsigned
// Q.FRAC_BITS and must be written only while the filter is idle.
module scalar_kalman_filter #(
	parameter int FRAC_BITS = 16,
	parameter int GAIN_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [skf_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [skf_pkg::DATA_W-1:0]           cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [skf_pkg::DATA_W-1:0]    measurement,
	input  logic                                 restart,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [skf_pkg::DATA_W-1:0]    estimate,
	output logic [GAIN_BITS:0]                   gain,
	output logic [skf_pkg::DATA_W-1:0]           error_variance
);

	localparam int DW = skf_pkg::DATA_W;
	localparam int AW = skf_pkg::ACC_W;
	localparam int GW = GAIN_BITS + 1;

	localparam logic [DW-1:0] TEN_FIX   = DW'(64'd10 << FRAC_BITS);
	localparam logic [DW-1:0] PN_RESET  = DW'((64'd1 << FRAC_BITS) / 100);
	localparam logic [DW-1:0] MN_RESET  = DW'(64'd1 << FRAC_BITS);
	localparam logic [GW-1:0] GAIN_ONE  = {1'b1, {GAIN_BITS{1'b0}}};
	localparam logic signed [AW+1:0] EST_MAX = (AW+2)'(64'sd2147483647);
	localparam logic signed [AW+1:0] EST_MIN = (AW+2)'(-64'sd2147483648);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PRIOR,
		ST_DEN,
		ST_DIV,
		ST_MUL,
		ST_UPD
	} state_t;

	state_t state_q;

	logic [DW-1:0]        pn_q;
	logic [DW-1:0]        mn_q;
	logic signed [DW-1:0] est_q;
	logic [DW-1:0]        var_q;

	logic signed [DW-1:0] meas_q;
	logic                 restart_q;
	logic [DW-1:0]        prior_q;
	logic [AW-1:0]        den_q;
	logic signed [AW-1:0] diff_q;
	logic [GW-1:0]        gain_q;
	logic signed [AW:0]   corr_q;
	logic [DW-1:0]        post_q;
	logic                 div_start_q;
	logic                 mul_start_q;

	logic                 out_valid_q;
	logic signed [DW-1:0] est_out_q;
	logic [GW-1:0]        gain_out_q;
	logic [DW-1:0]        var_out_q;

	logic [AW-1:0]        prior_sum;
	logic [DW-1:0]        prior_sat;
	logic [GW-1:0]        div_quo;
	logic                 div_done;
	logic signed [AW:0]   corr_prod;
	logic signed [AW:0]   post_prod;
	logic                 corr_done;
	logic                 post_done;
	logic signed [AW+1:0] est_sum;
	logic signed [DW-1:0] est_new;
	logic                 out_free;

	assign prior_sum = {1'b0, var_q} + {1'b0, pn_q};
	assign prior_sat = prior_sum[DW] ? {DW{1'b1}} : prior_sum[DW-1:0];

	assign est_sum = {{3{est_q[DW-1]}}, est_q} + {corr_q[AW], corr_q};

	always_comb begin
		if (est_sum > EST_MAX)
			est_new = {1'b0, {(DW-1){1'b1}}};
		else if (est_sum < EST_MIN)
			est_new = {1'b1, {(DW-1){1'b0}}};
		else
			est_new = est_sum[DW-1:0];
	end

	assign out_free = !out_valid_q || out_ready;

	skf_div #(
		.QW(GW)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start_q),
		.num   (prior_q),
		.den   (den_q),
		.quo   (div_quo),
		.done  (div_done)
	);

	skf_mul #(
		.AW(AW),
		.BW(GW)
	) u_mul_corr (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mul_start_q),
		.a     (diff_q),
		.b     (gain_q),
		.prod  (corr_prod),
		.done  (corr_done)
	);

	skf_mul #(
		.AW(AW),
		.BW(GW)
	) u_mul_var (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mul_start_q),
		.a     ($signed({1'b0, prior_q})),
		.b     (GAIN_ONE - gain_q),
		.prod  (post_prod),
		.done  (post_done)
	);

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pn_q <= PN_RESET;
			mn_q <= MN_RESET;
		end else if (cfg_we) begin
			case (skf_pkg::cfg_reg_t'(cfg_index))
				skf_pkg::REG_PROCESS_NOISE:     pn_q <= cfg_data;
				skf_pkg::REG_MEASUREMENT_NOISE: mn_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer, filter state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			est_q       <= '0;
			var_q       <= TEN_FIX;
			div_start_q <= 1'b0;
			mul_start_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			div_start_q <= 1'b0;
			mul_start_q <= 1'b0;
			// ST_UPD sets or holds the output word itself
			if (out_valid_q && out_ready && state_q != ST_UPD)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= restart ? ST_UPD : ST_PRIOR;
					end
				end
				ST_PRIOR: begin
					state_q <= ST_DEN;
				end
				ST_DEN: begin
					div_start_q <= 1'b1;
					state_q     <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						mul_start_q <= 1'b1;
						state_q     <= ST_MUL;
					end
				end
				ST_MUL: begin
					if (corr_done && post_done)
						state_q <= ST_UPD;
				end
				ST_UPD: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
						if (restart_q) begin
							est_q <= meas_q;
							var_q <= TEN_FIX;
						end else begin
							est_q <= est_new;
							var_q <= post_q;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			meas_q    <= measurement;
			restart_q <= restart;
		end
		if (state_q == ST_PRIOR)
			prior_q <= prior_sat;
		if (state_q == ST_DEN) begin
			den_q  <= {1'b0, prior_q} + {1'b0, mn_q};
			diff_q <= {meas_q[DW-1], meas_q} - {est_q[DW-1], est_q};
		end
		// zero denominator only when prior and R are both zero: gain 0
		if (state_q == ST_DIV && div_done)
			gain_q <= (den_q == '0) ? '0 : div_quo;
		if (state_q == ST_MUL && corr_done && post_done) begin
			corr_q <= corr_prod;
			post_q <= post_prod[DW-1:0];
		end
		if (state_q == ST_UPD && out_free) begin
			if (restart_q) begin
				est_out_q  <= meas_q;
				gain_out_q <= '0;
				var_out_q  <= TEN_FIX;
			end else begin
				est_out_q  <= est_new;
				gain_out_q <= gain_q;
				var_out_q  <= post_q;
			end
		end
	end

	assign in_ready       = (state_q == ST_IDLE);
	assign out_valid      = out_valid_q;
	assign estimate       = est_out_q;
	assign gain           = gain_out_q;
	assign error_variance = var_out_q;

endmodule
